>>> design/lscs_pkg.sv
// ----------------------------------------------------------------------------
// Limb stream to chunk splitter: shared definitions
// Widths, register indexes and the control word that travels from the
// front queue to the chunk engine.
// ----------------------------------------------------------------------------
package lscs_pkg;

  // Widest chunk magnitude and the signed chunk width.
  localparam int unsigned ChunkMaxBits = 52;
  localparam int unsigned ChunkW       = 53;

  // Configuration register widths.
  localparam int unsigned CbW = 6;
  localparam int unsigned CcW = 7;
  localparam int unsigned CfgDataW = 7;

  // Leading zero count width.
  localparam int unsigned LeadW = 12;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_CHUNK_BITS  = 1'b0,
    REG_CHUNK_COUNT = 1'b1
  } cfg_reg_e;

  // Per-limb control word, classified at the front.
  typedef struct packed {
    logic             first;
    logic             last;
    logic             negative;
    logic [LeadW-1:0] lead;
  } limb_ctl_t;

endpackage

>>> design/lscs_front.sv
// ----------------------------------------------------------------------------
// Limb stream to chunk splitter: front queue
// Accepts limb transfers and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module lscs_front #(
  parameter int unsigned LIMB_BITS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [LIMB_BITS-1:0]     limb_i,
  input  logic                     first_limb_i,
  input  logic                     last_limb_i,
  input  logic                     negative_i,
  input  logic [lscs_pkg::LeadW-1:0] lead_zero_bits_i,
  output logic                     q_valid_o,
  output lscs_pkg::limb_ctl_t      q_ctl_o,
  output logic [LIMB_BITS-1:0]     q_limb_o,
  input  logic                     q_pop_i
);
  import lscs_pkg::*;

  logic [LIMB_BITS-1:0] limb_mem [2];
  limb_ctl_t            ctl_mem  [2];
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [1:0]           fill_q, fill_d;
  logic                 push, pop;

  assign in_ready_o = (fill_q != 2'd2);
  assign q_valid_o  = (fill_q != 2'd0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_ctl_o    = ctl_mem[rd_ptr_q];
  assign q_limb_o   = limb_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      limb_mem[wr_ptr_q]         <= limb_i;
      ctl_mem[wr_ptr_q].first    <= first_limb_i;
      ctl_mem[wr_ptr_q].last     <= last_limb_i;
      ctl_mem[wr_ptr_q].negative <= negative_i;
      ctl_mem[wr_ptr_q].lead     <= lead_zero_bits_i;
    end
  end

endmodule

>>> design/lscs_back.sv
// ----------------------------------------------------------------------------
// Limb stream to chunk splitter: chunk engine
// Takes one queued limb at a time and emits at most one chunk per cycle
// into the output register: leading zero chunks, limb chunks, then padding.
// ----------------------------------------------------------------------------
module lscs_back #(
  parameter int unsigned LIMB_BITS  = 64,
  parameter int unsigned MAX_CHUNKS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lscs_pkg::CbW-1:0]       cb_i,
  input  logic [$clog2(MAX_CHUNKS+1)-1:0] cc_i,
  input  logic                           cfg_clear_i,
  input  logic                           q_valid_i,
  input  lscs_pkg::limb_ctl_t            q_ctl_i,
  input  logic [LIMB_BITS-1:0]           q_limb_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [lscs_pkg::ChunkW-1:0] chunk_o,
  output logic                           last_chunk_o
);
  import lscs_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned RW = $clog2(LIMB_BITS + 1);
  localparam int unsigned AW = $clog2(LIMB_BITS + ChunkMaxBits + 1);
  localparam int unsigned SW = 2 * ChunkMaxBits + LIMB_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ZEROS,
    ST_LIMB,
    ST_TAIL
  } state_e;

  state_e                  state_q;
  logic                    sign_q;
  logic                    last_q;
  logic [CW-1:0]           count_q;
  logic [LeadW-1:0]        lead_q;
  logic [CbW-1:0]          rc_q;
  logic [ChunkMaxBits-1:0] res_q;
  logic [LIMB_BITS-1:0]    sr_q;
  logic [RW-1:0]           rem_q;
  logic                    out_valid_q;
  logic [ChunkW-1:0]       out_chunk_q;
  logic                    out_last_q;

  logic                    live, fits, emit_ok, emit;
  logic [AW-1:0]           need, kk, amount;
  logic [SW-1:0]           shift_in, shift_out;
  logic [ChunkMaxBits-1:0] val, emit_mag;
  logic [ChunkW-1:0]       mag_ext;
  logic [CW-1:0]           count_inc;

  assign live      = (count_q < cc_i);
  assign emit_ok   = !out_valid_q || out_ready_i;
  assign need      = AW'(cb_i) - AW'(rc_q);
  assign fits      = (AW'(rc_q) + AW'(rem_q)) >= AW'(cb_i);
  assign count_inc = count_q + CW'(1);
  assign q_pop_o   = (state_q == ST_IDLE) && q_valid_i;

  // One right shift serves chunk cuts, residue appends and tail padding:
  // the result is res_q shifted left by kk with the top kk limb bits below.
  always_comb begin
    kk        = ((state_q == ST_LIMB) && !fits) ? AW'(rem_q) : need;
    amount    = AW'(LIMB_BITS + ChunkMaxBits) - kk;
    shift_in  = {res_q, sr_q, {ChunkMaxBits{1'b0}}};
    shift_out = shift_in >> amount;
    val       = shift_out[ChunkMaxBits-1:0];
  end

  always_comb begin
    emit     = 1'b0;
    emit_mag = '0;
    unique case (state_q)
      ST_ZEROS: emit = live && (lead_q >= LeadW'(cb_i)) && emit_ok;
      ST_LIMB: begin
        emit     = live && fits && emit_ok;
        emit_mag = val;
      end
      ST_TAIL: begin
        emit     = live && emit_ok;
        emit_mag = val;
      end
      default: emit = 1'b0;
    endcase
    mag_ext = {1'b0, emit_mag};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sign_q      <= 1'b0;
      last_q      <= 1'b0;
      count_q     <= '0;
      lead_q      <= '0;
      rc_q        <= '0;
      res_q       <= '0;
      sr_q        <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      out_chunk_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // Output register.
      if (emit) begin
        out_valid_q <= 1'b1;
        out_chunk_q <= sign_q ? (ChunkW'(0) - mag_ext) : mag_ext;
        out_last_q  <= (count_inc == cc_i);
        count_q     <= count_inc;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_clear_i) begin
        res_q   <= '0;
        rc_q    <= '0;
        count_q <= CW'(MAX_CHUNKS);
      end else begin
        unique case (state_q)
          ST_IDLE: begin
            if (q_valid_i) begin
              sr_q   <= q_limb_i;
              rem_q  <= RW'(LIMB_BITS);
              last_q <= q_ctl_i.last;
              if (q_ctl_i.first) begin
                sign_q  <= q_ctl_i.negative;
                count_q <= '0;
                res_q   <= '0;
                lead_q  <= q_ctl_i.lead;
                state_q <= ST_ZEROS;
              end else begin
                state_q <= ST_LIMB;
              end
            end
          end
          ST_ZEROS: begin
            if (live && (lead_q >= LeadW'(cb_i))) begin
              if (emit_ok) begin
                lead_q <= lead_q - LeadW'(cb_i);
              end
            end else begin
              // Leftover leading zeros become the residue width.
              rc_q    <= lead_q[CbW-1:0];
              state_q <= ST_LIMB;
            end
          end
          ST_LIMB: begin
            if (live && fits) begin
              if (emit_ok) begin
                res_q <= '0;
                rc_q  <= '0;
                sr_q  <= sr_q << need;
                rem_q <= rem_q - RW'(need);
              end
            end else begin
              if (live && (rem_q != '0)) begin
                res_q <= val;
                rc_q  <= rc_q + CbW'(rem_q);
                sr_q  <= '0;
                rem_q <= '0;
              end
              state_q <= last_q ? ST_TAIL : ST_IDLE;
            end
          end
          ST_TAIL: begin
            if (live) begin
              if (emit_ok) begin
                res_q <= '0;
                rc_q  <= '0;
              end
            end else begin
              res_q   <= '0;
              rc_q    <= '0;
              state_q <= ST_IDLE;
            end
          end
          default: state_q <= ST_IDLE;
        endcase
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign chunk_o      = out_chunk_q;
  assign last_chunk_o = out_last_q;

endmodule

>>> design/limb_stream_to_chunk_splitter_core.sv
// ----------------------------------------------------------------------------
// Limb stream to chunk splitter
// Regroups the mantissa bits of a sign-magnitude multi-precision number,
// fed as limbs most significant first, into signed chunks of a set width.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_ready_o    limb, first/last, sign, lead
//   out      output     out_valid_o / out_ready_i  chunk, last_chunk
//   cfg      input      cfg_we_i (no wait)         cfg_index_i, cfg_wdata_i
//
// The engine loads each limb, cuts the chunks it yields, and then folds its
// leftover bits into the residue. A first limb is preceded by its leading
// zero chunks; a last limb is followed by the flushed residue and padding
// chunks. The single shared shifter in the engine cuts one chunk per cycle
// while the output register can take it.
// Reset leaves a positive number without leading zeros in progress. A full
// output register stalls the engine; the two-entry queue keeps taking limbs until full.
//
module limb_stream_to_chunk_splitter_core #(
  parameter int unsigned LIMB_BITS  = 64,
  parameter int unsigned MAX_CHUNKS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  lscs_pkg::cfg_reg_e                cfg_index_i,
  input  logic [lscs_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [LIMB_BITS-1:0]              limb_i,
  input  logic                              first_limb_i,
  input  logic                              last_limb_i,
  input  logic                              negative_i,
  input  logic [lscs_pkg::LeadW-1:0]        lead_zero_bits_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [lscs_pkg::ChunkW-1:0] chunk_o,
  output logic                              last_chunk_o
);
  import lscs_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);

  logic [CbW-1:0]  chunk_bits_q;
  logic [CcW-1:0]  chunk_count_q;
  logic [CbW-1:0]  cb_eff;
  logic [CW-1:0]   cc_eff;
  logic            q_valid, q_pop;
  limb_ctl_t       q_ctl;
  logic [LIMB_BITS-1:0] q_limb;

  // Configuration registers. Any write abandons the number in progress,
  // which the engine handles through the write enable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_bits_q  <= CbW'(24);
      chunk_count_q <= CcW'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CHUNK_BITS:  chunk_bits_q  <= cfg_wdata_i[CbW-1:0];
        REG_CHUNK_COUNT: chunk_count_q <= cfg_wdata_i[CcW-1:0];
        default:         chunk_bits_q  <= chunk_bits_q;
      endcase
    end
  end

  // Out-of-range settings are clamped to the nearest meaningful value.
  always_comb begin
    if (chunk_bits_q == '0) begin
      cb_eff = CbW'(1);
    end else if (chunk_bits_q > CbW'(ChunkMaxBits)) begin
      cb_eff = CbW'(ChunkMaxBits);
    end else begin
      cb_eff = chunk_bits_q;
    end
    if (chunk_count_q == '0) begin
      cc_eff = CW'(1);
    end else if (chunk_count_q > CcW'(MAX_CHUNKS)) begin
      cc_eff = CW'(MAX_CHUNKS);
    end else begin
      cc_eff = CW'(chunk_count_q);
    end
  end

  lscs_front #(
    .LIMB_BITS (LIMB_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .limb_i           (limb_i),
    .first_limb_i     (first_limb_i),
    .last_limb_i      (last_limb_i),
    .negative_i       (negative_i),
    .lead_zero_bits_i (lead_zero_bits_i),
    .q_valid_o        (q_valid),
    .q_ctl_o          (q_ctl),
    .q_limb_o         (q_limb),
    .q_pop_i          (q_pop)
  );

  lscs_back #(
    .LIMB_BITS  (LIMB_BITS),
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cb_i         (cb_eff),
    .cc_i         (cc_eff),
    .cfg_clear_i  (cfg_we_i),
    .q_valid_i    (q_valid),
    .q_ctl_i      (q_ctl),
    .q_limb_i     (q_limb),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .chunk_o      (chunk_o),
    .last_chunk_o (last_chunk_o)
  );

endmodule

>>> verif/tb_limb_stream_to_chunk_splitter_core.sv
// ----------------------------------------------------------------------------
// Limb stream to chunk splitter: self-checking testbench
// Feeds mantissa limbs through a valid/ready channel with random gaps, predicts
// every chunk in a behavioral model of the gearbox, and checks the chunk
// stream under random back-pressure across a sweep of width and count settings.
// ----------------------------------------------------------------------------
module tb_limb_stream_to_chunk_splitter_core;
  import lscs_pkg::*;

  localparam int unsigned LimbW        = 64;
  localparam int unsigned MaxChunks    = 64;
  // Cycles allowed after the last expected chunk so that limbs which yield no
  // chunk can leave the front queue and the engine before a register write.
  localparam int unsigned SettleCycles = 200;
  // Cycles without any transfer on either channel before the run is declared hung.
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned PhaseItems   = 50;

  typedef struct packed {
    logic [LimbW-1:0] limb;
    logic             first;
    logic             last;
    logic             negative;
    logic [LeadW-1:0] lead;
  } limb_item_t;

  typedef struct {
    logic signed [ChunkW-1:0] value;
    logic                     last;
  } chunk_exp_t;

  // Block ports. Every input carries a known value from time zero.
  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  cfg_reg_e                 cfg_index_i = REG_CHUNK_BITS;
  logic [CfgDataW-1:0]      cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [LimbW-1:0]         limb_i = '0;
  logic                     first_limb_i = 1'b0;
  logic                     last_limb_i = 1'b0;
  logic                     negative_i = 1'b0;
  logic [LeadW-1:0]         lead_zero_bits_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [ChunkW-1:0] chunk_o;
  logic                     last_chunk_o;

  // Limbs waiting to be offered, and chunks predicted but not yet seen.
  limb_item_t limb_backlog_q[$];
  chunk_exp_t chunk_expect_q[$];

  // Gearbox model state and its copy of the two registers.
  logic [CbW-1:0] model_chunk_bits  = 6'd24;
  logic [CcW-1:0] model_chunk_count = 7'd16;
  logic [63:0]    held_bits  = '0;
  int unsigned    held_count = 0;
  int unsigned    emitted    = 0;
  bit             held_sign  = 1'b0;

  // Pacing state for both channels. A calm side runs without gaps.
  int unsigned in_gap   = 0;
  int unsigned out_gap  = 0;
  bit          in_calm  = 1'b0;
  bit          out_calm = 1'b0;

  int unsigned errors         = 0;
  int unsigned limbs_sent     = 0;
  int unsigned chunks_checked = 0;
  int unsigned reg_writes     = 0;
  int unsigned idle_cycles    = 0;

  limb_stream_to_chunk_splitter_core #(
    .LIMB_BITS (LimbW),
    .MAX_CHUNKS(MaxChunks)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .limb_i          (limb_i),
    .first_limb_i    (first_limb_i),
    .last_limb_i     (last_limb_i),
    .negative_i      (negative_i),
    .lead_zero_bits_i(lead_zero_bits_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .chunk_o         (chunk_o),
    .last_chunk_o    (last_chunk_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Gearbox model
  // --------------------------------------------------------------------------

  function automatic logic [63:0] ones_below(input int unsigned n);
    return (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
  endfunction

  // Register values outside the meaningful range are clamped, not rejected.
  function automatic int unsigned live_chunk_bits();
    if (model_chunk_bits == 0) return 1;
    if (model_chunk_bits > ChunkMaxBits) return ChunkMaxBits;
    return model_chunk_bits;
  endfunction

  function automatic int unsigned live_chunk_count();
    if (model_chunk_count == 0) return 1;
    if (model_chunk_count > MaxChunks) return MaxChunks;
    return model_chunk_count;
  endfunction

  // Records one chunk. The sign is applied in two's complement and the result
  // is cut to the chunk port width; the chunk that reaches the count is marked.
  task automatic push_chunk(input logic [63:0] mag, input int unsigned cc);
    chunk_exp_t  e;
    logic [63:0] with_sign;
    with_sign = held_sign ? (64'd0 - mag) : mag;
    emitted++;
    e.value = with_sign[ChunkW-1:0];
    e.last  = (emitted == cc);
    chunk_expect_q.push_back(e);
  endtask

  // Runs one accepted limb through the model and queues the chunks it yields.
  task automatic split_limb(input limb_item_t it);
    int unsigned cb;
    int unsigned cc;
    int unsigned z;
    int unsigned rem;
    int unsigned need;
    logic [63:0] top;
    cb = live_chunk_bits();
    cc = live_chunk_count();
    // A first limb opens a number: whole chunks of leading zeros go out at
    // once, and the leftover zero bits start the residue.
    if (it.first) begin
      z          = it.lead / cb;
      held_sign  = it.negative;
      held_bits  = '0;
      emitted    = 0;
      while (z > 0 && emitted < cc) begin
        push_chunk(64'd0, cc);
        z--;
      end
      held_count = it.lead % cb;
    end
    // Cut chunks from the top of the limb while the residue and the limb
    // bits still fill one; the bits left over join the residue.
    if (emitted < cc) begin
      rem = LimbW;
      while (emitted < cc && held_count + rem >= cb) begin
        need = cb - held_count;
        top  = (it.limb >> (rem - need)) & ones_below(need);
        push_chunk((held_bits << need) | top, cc);
        held_bits  = '0;
        held_count = 0;
        rem        = rem - need;
      end
      if (emitted < cc && rem > 0) begin
        held_bits  = (held_bits << rem) | (it.limb & ones_below(rem));
        held_count = held_count + rem;
      end
    end
    // The last limb flushes the residue left-aligned and pads with zero chunks.
    if (it.last) begin
      if (emitted < cc && held_count > 0) push_chunk(held_bits << (cb - held_count), cc);
      while (emitted < cc) push_chunk(64'd0, cc);
      held_bits  = '0;
      held_count = 0;
    end
  endtask

  // Any register write abandons the number in progress: nothing more comes
  // out until the next first limb.
  task automatic apply_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    if (idx == REG_CHUNK_BITS) model_chunk_bits = val[CbW-1:0];
    else model_chunk_count = val[CcW-1:0];
    held_bits  = '0;
    held_count = 0;
    emitted    = MaxChunks;
  endtask

  // --------------------------------------------------------------------------
  // Pacing: mostly no gap or a short one, now and then a long one.
  // --------------------------------------------------------------------------

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Limb driver. A limb is handed to the model at the edge where its transfer
  // completes, taken from the port values the block actually sampled. A new
  // limb is presented only once the previous one has gone, so valid never
  // drops while a limb is pending.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_limbs
    limb_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        split_limb({limb_i, first_limb_i, last_limb_i, negative_i, lead_zero_bits_i});
        limbs_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (limb_backlog_q.size() > 0) begin
          nxt = limb_backlog_q.pop_front();
          in_valid_i       <= 1'b1;
          limb_i           <= nxt.limb;
          first_limb_i     <= nxt.first;
          last_limb_i      <= nxt.last;
          negative_i       <= nxt.negative;
          lead_zero_bits_i <= nxt.lead;
          if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
          in_gap = pick_gap(in_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Chunk monitor. Every chunk transfer is compared against the oldest
  // prediction, value and end marker separately. Ready is dropped for random
  // stretches independently of what the block is doing.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : check_chunks
    chunk_exp_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        chunks_checked++;
        if (chunk_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected chunk: expected none, actual %0d last %0b",
                   $time, chunk_o, last_chunk_o);
        end else begin
          want = chunk_expect_q.pop_front();
          if (chunk_o !== want.value) begin
            errors++;
            $display("%0t: chunk value mismatch: expected %0d, actual %0d",
                     $time, want.value, chunk_o);
          end
          if (last_chunk_o !== want.last) begin
            errors++;
            $display("%0t: last_chunk mismatch: expected %0b, actual %0b",
                     $time, want.last, last_chunk_o);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
        out_gap = pick_gap(out_calm);
      end
    end
  end

  // Hang detection: the run ends if neither channel completes a transfer for
  // too long.
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d chunks still expected",
               $time, idle_cycles, chunk_expect_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic add_limb(input logic [LimbW-1:0] limb, input bit first, input bit last,
                          input bit negative, input logic [LeadW-1:0] lead);
    limb_item_t it;
    it.limb     = limb;
    it.first    = first;
    it.last     = last;
    it.negative = negative;
    it.lead     = lead;
    limb_backlog_q.push_back(it);
  endtask

  function automatic logic [LimbW-1:0] random_limb();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 14) return {LimbW{1'b1}};
    if (r < 20) return 64'd1 << $urandom_range(0, LimbW - 1);
    return {$urandom, $urandom};
  endfunction

  // Waits until every limb has been transferred and every chunk has arrived,
  // then lets the engine settle. Sampled on the falling edge so the check
  // never races the driver and monitor.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (limb_backlog_q.size() != 0 || in_valid_i || chunk_expect_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    apply_reg(idx, val);
    reg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Queues one number: a first limb, middle limbs, a last limb. A minority of
  // numbers are broken on purpose: missing first flag, missing last flag, or a
  // stray limb after the last one. Stray limbs are not counted.
  task automatic gen_number(output int unsigned counted);
    int unsigned      len;
    int unsigned      r;
    int unsigned      noise;
    logic [LeadW-1:0] lead;
    bit               neg;
    r     = $urandom_range(0, 99);
    len   = (r < 55) ? $urandom_range(1, 2) : (r < 90) ? $urandom_range(3, 4)
                                                       : $urandom_range(5, 8);
    r     = $urandom_range(0, 99);
    lead  = LeadW'((r < 50) ? $urandom_range(0, 63) : (r < 85) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 4095));
    neg   = 1'($urandom_range(0, 1));
    noise = $urandom_range(0, 99);
    counted = 0;
    for (int unsigned k = 0; k < len; k++) begin
      // Sign and lead on later limbs are don't-care, so they carry noise.
      add_limb(random_limb(), (k == 0) && (noise >= 6),
               (k == len - 1) && !(noise >= 6 && noise < 12),
               (k == 0) ? neg : 1'($urandom), (k == 0) ? lead : 12'($urandom));
      counted++;
    end
    if (noise >= 12 && noise < 18) add_limb(random_limb(), 1'b0, 1'b0, 1'($urandom),
                                            12'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [CfgDataW-1:0] cb_tab[6];
    logic [CfgDataW-1:0] cc_tab[6];
    logic [CfgDataW-1:0] cb_w;
    logic [CfgDataW-1:0] cc_w;
    int unsigned         made;
    int unsigned         got;
    // The first settings are the corners: narrowest chunk with the most
    // chunks, widest chunk with a single chunk, zero in both registers, and
    // values above range in both. Register bit 6 is set by the fourth entry and the first count.
    cb_tab = '{7'd1, 7'd52, 7'd0, 7'd127, 7'd24, 7'd7};
    cc_tab = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd16, 7'd3};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, running at the reset settings (24-bit chunks, 16 chunks).
    // Right after reset a limb without a first flag continues a positive
    // number with no leading zeros; its sign and lead fields are ignored.
    add_limb(64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 1'b1, 12'hFFF);
    add_limb({LimbW{1'b1}}, 1'b0, 1'b1, 1'b0, 12'h000);
    // A limb after the last one yields nothing.
    add_limb(64'hDEAD_BEEF_0000_FFFF, 1'b0, 1'b0, 1'b0, 12'h000);
    // Single-limb numbers: full magnitude negative, zero, smallest negative.
    add_limb({LimbW{1'b1}}, 1'b1, 1'b1, 1'b1, 12'h000);
    add_limb('0, 1'b1, 1'b1, 1'b0, 12'h000);
    add_limb(64'd1, 1'b1, 1'b1, 1'b1, 12'h000);
    // The most leading zeros use up the whole count on the first limb; the
    // rest of the number, last limb included, yields nothing.
    add_limb(random_limb(), 1'b1, 1'b0, 1'b1, 12'hFFF);
    add_limb(random_limb(), 1'b0, 1'b0, 1'b0, 12'h000);
    add_limb(random_limb(), 1'b0, 1'b1, 1'b0, 12'h000);
    // A long number whose limbs reach the count before the last limb, with a
    // lead one bit short of a whole chunk.
    add_limb({LimbW{1'b1}}, 1'b1, 1'b0, 1'b0, 12'd23);
    for (int unsigned k = 0; k < 6; k++) add_limb(random_limb(), 1'b0, 1'b0, 1'b0, 12'h000);
    add_limb(random_limb(), 1'b0, 1'b1, 1'b0, 12'h000);
    // A register write in the middle of a number abandons it: the limbs that
    // follow without a first flag yield nothing.
    add_limb(random_limb(), 1'b1, 1'b0, 1'b1, 12'd5);
    wait_idle();
    write_reg(REG_CHUNK_COUNT, 7'd16);
    @(negedge clk_i);
    add_limb(random_limb(), 1'b0, 1'b0, 1'b0, 12'h000);
    add_limb(random_limb(), 1'b0, 1'b1, 1'b0, 12'h000);

    // Random part: each phase runs at one setting, written while idle.
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      wait_idle();
      if (phase < 6) begin
        cb_w = cb_tab[phase];
        cc_w = cc_tab[phase];
      end else begin
        cb_w = CfgDataW'($urandom_range(0, 127));
        cc_w = CfgDataW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(1, 20));
      end
      if ($urandom_range(0, 1) == 1) begin
        write_reg(REG_CHUNK_BITS, cb_w);
        write_reg(REG_CHUNK_COUNT, cc_w);
      end else begin
        write_reg(REG_CHUNK_COUNT, cc_w);
        write_reg(REG_CHUNK_BITS, cb_w);
      end
      @(negedge clk_i);
      // Each phase opens with a single full-scale limb; the first phase gives
      // it the largest lead, which fills all 64 one-bit chunks with zeros.
      add_limb({LimbW{1'b1}}, 1'b1, 1'b1, phase[0], (phase == 0) ? 12'hFFF : 12'h000);
      made = 1;
      while (made < PhaseItems) begin
        gen_number(got);
        made = made + got;
      end
    end

    wait_idle();
    $display("Run covered %0d limb transfers and %0d checked chunks over %0d register writes.",
             limbs_sent, chunks_checked, reg_writes);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches found", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> limb_stream_to_chunk_splitter_core.f
design/lscs_pkg.sv
design/lscs_front.sv
design/lscs_back.sv
design/limb_stream_to_chunk_splitter_core.sv
verif/tb_limb_stream_to_chunk_splitter_core.sv
